[hw/rtl/assert_macros.svh]
// Assertion helpers, included by segment_frame_point_transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, suspended while reset is held.
`define SFPT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define SFPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/sfpt_pkg.sv]
package sfpt_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int ANGLE_STAGES_DEF = 16;
    localparam int HEADING_W        = 16;
    localparam int ACC_W            = 32;
    localparam int GAIN_W           = 30;
    localparam int GAIN_LO_W        = 20;

    // Reciprocal of the CORDIC gain in Q0.30.
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'h26DD3B6A;

    localparam logic [HEADING_W-1:0] HEADING_ZERO  = 16'h0000;
    localparam logic [HEADING_W-1:0] HEADING_QTR   = 16'h4000;
    localparam logic [HEADING_W-1:0] HEADING_HALF  = 16'h8000;
    localparam logic [HEADING_W-1:0] HEADING_3QTR  = 16'hC000;
    localparam logic [ACC_W-1:0]     ACC_HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0]     ACC_ROUND     = 32'h0000_8000;

    // Quarter of the turn taken from the top two heading bits.
    typedef enum logic [1:0] {
        QTR_0,
        QTR_1,
        QTR_2,
        QTR_3
    } quarter_t;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [ACC_W-1:0] atan_turn(input int idx);
        logic [ACC_W-1:0] t;
        case (idx)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/sfpt_vec_cell.sv]
module sfpt_vec_cell
    import sfpt_pkg::*;
#(
    parameter int VW  = 35,
    parameter int IDX = 0,
    parameter int SW  = 8
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  logic [ACC_W-1:0]     acc_in,
    input  logic [SW-1:0]        side_in,
    output logic signed [VW-1:0] x_out,
    output logic signed [VW-1:0] y_out,
    output logic [ACC_W-1:0]     acc_out,
    output logic [SW-1:0]        side_out
);

    logic signed [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [SW-1:0]        side_reg;
    logic signed [VW-1:0] sx, sy;

    // One vectoring step: turn the vector toward the positive X axis.
    always_comb begin
        sx = x_in >>> IDX;
        sy = y_in >>> IDX;
        if (!y_in[VW-1]) begin
            x_next   = x_in + sy;
            y_next   = y_in - sx;
            acc_next = acc_in + atan_turn(IDX);
        end else begin
            x_next   = x_in - sy;
            y_next   = y_in + sx;
            acc_next = acc_in - atan_turn(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign acc_out  = acc_reg;
    assign side_out = side_reg;

endmodule

[hw/rtl/sfpt_rot_cell.sv]
module sfpt_rot_cell
    import sfpt_pkg::*;
#(
    parameter int RW  = 35,
    parameter int IDX = 0,
    parameter int SW  = 8
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic                    act_in,
    input  logic signed [RW-1:0]    x_in,
    input  logic signed [RW-1:0]    y_in,
    input  logic signed [ACC_W-1:0] z_in,
    input  logic [SW-1:0]           side_in,
    output logic                    act_out,
    output logic signed [RW-1:0]    x_out,
    output logic signed [RW-1:0]    y_out,
    output logic signed [ACC_W-1:0] z_out,
    output logic [SW-1:0]           side_out
);

    logic                    act_reg;
    logic signed [RW-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [ACC_W-1:0] z_reg, z_next;
    logic [SW-1:0]           side_reg;
    logic signed [RW-1:0]    sx, sy;

    // One rotation step; an item on an exact quarter turn passes untouched.
    always_comb begin
        sx     = x_in >>> IDX;
        sy     = y_in >>> IDX;
        x_next = x_in;
        y_next = y_in;
        z_next = z_in;
        if (act_in) begin
            if (!z_in[ACC_W-1]) begin
                x_next = x_in - sy;
                y_next = y_in + sx;
                z_next = z_in - $signed(atan_turn(IDX));
            end else begin
                x_next = x_in + sy;
                y_next = y_in - sx;
                z_next = z_in + $signed(atan_turn(IDX));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg  <= act_in;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign act_out  = act_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

[hw/rtl/sfpt_gain.sv]
module sfpt_gain
    import sfpt_pkg::*;
#(
    parameter int RW = 35
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 act_in,
    input  logic signed [RW-1:0] v_in,
    output logic signed [RW-1:0] v_out
);

    localparam int MW = (RW > GAIN_LO_W + 1) ? RW : GAIN_LO_W + 1;
    localparam int HW = MW - GAIN_LO_W;
    localparam int AW = HW + GAIN_W;
    localparam int BW = GAIN_LO_W + GAIN_W;
    localparam int TW = BW + 1;

    logic [RW-1:0]        mag;
    logic [MW-1:0]        mag_ext;
    logic [AW-1:0]        a_reg, a_next;
    logic [BW-1:0]        b_reg, b_next;
    logic                 neg_reg, act_reg;
    logic signed [RW-1:0] v_reg, v_res_reg, v_res_next;
    logic [TW-1:0]        t_sum;
    logic [AW-1:0]        r_full;
    logic [RW-1:0]        r_mag;

    // First stage: magnitude split in two partial products with the gain.
    always_comb begin
        mag     = v_in[RW-1] ? RW'(-v_in) : RW'(v_in);
        mag_ext = MW'(mag);
        a_next  = AW'(mag_ext[MW-1:GAIN_LO_W]) * AW'(INV_GAIN_Q30);
        b_next  = BW'(mag_ext[GAIN_LO_W-1:0]) * BW'(INV_GAIN_Q30);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            neg_reg <= v_in[RW-1];
            act_reg <= act_in;
            v_reg   <= v_in;
        end
    end

    // Second stage: join the partial products, round half away from zero.
    always_comb begin
        t_sum  = TW'({a_reg[9:0], {GAIN_LO_W{1'b0}}}) + TW'(b_reg)
               + (TW'(1) << (GAIN_W - 1));
        r_full = (a_reg >> 10) + AW'(t_sum[TW-1:GAIN_W]);
        r_mag  = r_full[RW-1:0];
        if (!act_reg) begin
            v_res_next = v_reg;
        end else if (neg_reg) begin
            v_res_next = -$signed(r_mag);
        end else begin
            v_res_next = $signed(r_mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_res_reg <= v_res_next;
        end
    end

    assign v_out = v_res_reg;

endmodule

[hw/rtl/segment_frame_point_transform.sv]
// Moves a point into the frame of a segment: the segment heading is found by a
// chain of CORDIC vectoring cells, the point XY is turned by that heading in a
// chain of CORDIC rotation cells, scaled by the inverse gain and shifted by the
// segment begin point, with saturation. One item enters per clock unless the
// pipeline is stalled, and it stops as a whole only while m_tvalid is high
// and m_tready low. s_tdata carries seg_begin_x, seg_begin_y, seg_begin_z,
// seg_end_x, seg_end_y, point_x, point_y, point_z from the lowest bit up;
// m_tdata carries moved_x, moved_y, moved_z, heading, and m_tuser is the
// saturated flag.
module segment_frame_point_transform
    import sfpt_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // seg_begin_x, seg_begin_y, seg_begin_z, seg_end_x, seg_end_y,
    // point_x, point_y, point_z
    input  logic [8*COORD_WIDTH-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // moved_x, moved_y, moved_z, heading, zero fill
    output logic [((3*COORD_WIDTH+HEADING_W+7)/8)*8-1:0] m_tdata,
    // saturated
    output logic                     m_tuser
);

    `include "assert_macros.svh"

    localparam int CW  = COORD_WIDTH;
    localparam int N   = ANGLE_STAGES;
    localparam int VW  = CW + 3;
    localparam int RW  = CW + 3;
    localparam int OW  = ((3*CW + HEADING_W + 7) / 8) * 8;
    localparam int TOT = 2*N + 4;
    localparam int VSW = 6*CW + 1 + HEADING_W;
    localparam int RSW = 4*CW + HEADING_W;

    logic                 adv;
    logic [TOT-1:0]       valid_reg, valid_next;

    // Input stage.
    logic signed [CW-1:0] bx_reg, by_reg, bz_reg, px_reg, py_reg, pz_reg;
    logic signed [CW:0]   dx_reg, dy_reg;

    assign adv        = !valid_reg[TOT-1] || m_tready;
    assign s_tready   = adv;
    assign valid_next = {valid_reg[TOT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bx_reg <= s_tdata[0*CW +: CW];
            by_reg <= s_tdata[1*CW +: CW];
            bz_reg <= s_tdata[2*CW +: CW];
            dx_reg <= (CW+1)'($signed(s_tdata[3*CW +: CW]))
                    - (CW+1)'($signed(s_tdata[0*CW +: CW]));
            dy_reg <= (CW+1)'($signed(s_tdata[4*CW +: CW]))
                    - (CW+1)'($signed(s_tdata[1*CW +: CW]));
            px_reg <= s_tdata[5*CW +: CW];
            py_reg <= s_tdata[6*CW +: CW];
            pz_reg <= s_tdata[7*CW +: CW];
        end
    end

    // Vectoring entry: axis cases and the fold into the right half plane.
    logic signed [VW-1:0] vx [0:N];
    logic signed [VW-1:0] vy [0:N];
    logic [ACC_W-1:0]     vacc [0:N];
    logic [VSW-1:0]       vside [0:N];
    logic                 axis;
    logic [HEADING_W-1:0] axis_hd;

    always_comb begin
        axis    = (dx_reg == '0) || (dy_reg == '0);
        axis_hd = HEADING_ZERO;
        if (dy_reg == '0) begin
            axis_hd = dx_reg[CW] ? HEADING_HALF : HEADING_ZERO;
        end else if (dx_reg == '0) begin
            axis_hd = dy_reg[CW] ? HEADING_3QTR : HEADING_QTR;
        end
        if (dx_reg[CW]) begin
            vx[0]   = -VW'(dx_reg);
            vy[0]   = -VW'(dy_reg);
            vacc[0] = ACC_HALF_TURN;
        end else begin
            vx[0]   = VW'(dx_reg);
            vy[0]   = VW'(dy_reg);
            vacc[0] = '0;
        end
        vside[0] = {axis_hd, axis, pz_reg, py_reg, px_reg, bz_reg, by_reg, bx_reg};
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        sfpt_vec_cell #(.VW(VW), .IDX(k), .SW(VSW)) u_cell (
            .aclk     (aclk),
            .en       (adv),
            .x_in     (vx[k]),
            .y_in     (vy[k]),
            .acc_in   (vacc[k]),
            .side_in  (vside[k]),
            .x_out    (vx[k+1]),
            .y_out    (vy[k+1]),
            .acc_out  (vacc[k+1]),
            .side_out (vside[k+1])
        );
    end

    // Heading and the exact quarter-turn rotation of the point.
    logic [ACC_W-1:0]        acc_rnd;
    logic [HEADING_W-1:0]    heading;
    logic signed [RW-1:0]    qx, qy;
    logic signed [CW-1:0]    vpx, vpy;
    logic                    rx_act [0:N];
    logic signed [RW-1:0]    rx [0:N];
    logic signed [RW-1:0]    ry [0:N];
    logic signed [ACC_W-1:0] rz [0:N];
    logic [RSW-1:0]          rside [0:N];

    always_comb begin
        acc_rnd = vacc[N] + ACC_ROUND;
        heading = vside[N][6*CW] ? vside[N][6*CW+1 +: HEADING_W]
                                 : acc_rnd[ACC_W-1 -: HEADING_W];
        vpx = vside[N][3*CW +: CW];
        vpy = vside[N][4*CW +: CW];
        case (quarter_t'(heading[HEADING_W-1 -: 2]))
            QTR_1: begin
                qx = -RW'(vpy);
                qy = RW'(vpx);
            end
            QTR_2: begin
                qx = -RW'(vpx);
                qy = -RW'(vpy);
            end
            QTR_3: begin
                qx = RW'(vpy);
                qy = -RW'(vpx);
            end
            default: begin
                qx = RW'(vpx);
                qy = RW'(vpy);
            end
        endcase
        rx_act[0] = (heading[HEADING_W-3:0] != '0);
        rx[0]     = qx;
        ry[0]     = qy;
        rz[0]     = {2'b00, heading[HEADING_W-3:0], 16'h0000};
        rside[0]  = {heading, vside[N][5*CW +: CW], vside[N][0 +: 3*CW]};
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        sfpt_rot_cell #(.RW(RW), .IDX(k), .SW(RSW)) u_cell (
            .aclk     (aclk),
            .en       (adv),
            .act_in   (rx_act[k]),
            .x_in     (rx[k]),
            .y_in     (ry[k]),
            .z_in     (rz[k]),
            .side_in  (rside[k]),
            .act_out  (rx_act[k+1]),
            .x_out    (rx[k+1]),
            .y_out    (ry[k+1]),
            .z_out    (rz[k+1]),
            .side_out (rside[k+1])
        );
    end

    // Gain correction, two stages; the side data follows in step.
    logic signed [RW-1:0] gx, gy;
    logic [RSW-1:0]       gside1_reg, gside2_reg;

    sfpt_gain #(.RW(RW)) u_gain_x (
        .aclk   (aclk),
        .en     (adv),
        .act_in (rx_act[N]),
        .v_in   (rx[N]),
        .v_out  (gx)
    );

    sfpt_gain #(.RW(RW)) u_gain_y (
        .aclk   (aclk),
        .en     (adv),
        .act_in (rx_act[N]),
        .v_in   (ry[N]),
        .v_out  (gy)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            gside1_reg <= rside[N];
            gside2_reg <= gside1_reg;
        end
    end

    // Translation by the begin point with saturation.
    function automatic logic [CW:0] clamp_sum(input logic signed [RW:0] s);
        logic signed [RW:0] hi, lo;
        hi = {{(RW-CW+2){1'b0}}, {(CW-1){1'b1}}};
        lo = {{(RW-CW+2){1'b1}}, {(CW-1){1'b0}}};
        if (s > hi) begin
            return {1'b1, hi[CW-1:0]};
        end else if (s < lo) begin
            return {1'b1, lo[CW-1:0]};
        end
        return {1'b0, s[CW-1:0]};
    endfunction

    logic [CW:0]          cx, cy, cz;
    logic [OW-1:0]        m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    always_comb begin
        cx = clamp_sum((RW+1)'(gx) + (RW+1)'($signed(gside2_reg[0*CW +: CW])));
        cy = clamp_sum((RW+1)'(gy) + (RW+1)'($signed(gside2_reg[1*CW +: CW])));
        cz = clamp_sum((RW+1)'($signed(gside2_reg[3*CW +: CW]))
                     + (RW+1)'($signed(gside2_reg[2*CW +: CW])));
        m_tdata_next = OW'({gside2_reg[4*CW +: HEADING_W], cz[CW-1:0], cy[CW-1:0],
                            cx[CW-1:0]});
        m_tuser_next = cx[CW] || cy[CW] || cz[CW];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = valid_reg[TOT-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An empty output register never holds back the input side.
    `SFPT_ASSERT(a_empty_accepts, aclk, aresetn, !m_tvalid |-> s_tready, "input blocked")
    // A stalled pipeline keeps every item where it is.
    `SFPT_ASSERT(a_stall_holds, aclk, aresetn, !adv |=> $stable(valid_reg), "pipe moved")
    // An accepted item enters the first stage.
    `SFPT_ASSERT(a_accept_enters, aclk, aresetn, (s_tvalid && s_tready) |=> valid_reg[0],
        "item lost")

endmodule
